FILE: hw/rtl/a2u_pkg.sv
// Package for the ASCII number to uint32 parser.
// Holds the parser state type and the character and limit constants.
// No dependencies.
package a2u_pkg;

    // Parser state carried from one character to the next
    typedef struct packed {
        logic [1:0]  char_position;
        logic        hex_mode;
        logic [31:0] accumulator;
        logic        failed;
    } t_parse_state;

    localparam logic [1:0]  POS_FIRST  = 2'd0;
    localparam logic [1:0]  POS_SECOND = 2'd1;
    localparam logic [1:0]  POS_LATER  = 2'd2;

    localparam logic [7:0]  CH_0     = 8'h30;
    localparam logic [7:0]  CH_5     = 8'h35;
    localparam logic [7:0]  CH_9     = 8'h39;
    localparam logic [7:0]  CH_A_UP  = 8'h41;
    localparam logic [7:0]  CH_F_UP  = 8'h46;
    localparam logic [7:0]  CH_A_LO  = 8'h61;
    localparam logic [7:0]  CH_F_LO  = 8'h66;
    localparam logic [7:0]  CH_X_UP  = 8'h58;
    localparam logic [7:0]  CH_X_LO  = 8'h78;

    // Largest accumulator that may still take a decimal digit
    localparam logic [31:0] DEC_LIMIT = 32'd429496729;
    // Largest accumulator that may still take a hex digit
    localparam logic [31:0] HEX_LIMIT = 32'h0FFF_FFFF;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

endpackage

FILE: hw/rtl/a2u_ifs.sv
// Valid/ready channel interfaces of the ASCII number parser.
// Input channel carries one character, output channel one parsed value.
// No dependencies.
interface a2u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface a2u_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

FILE: hw/rtl/ascii_number_to_uint32.sv
// ASCII number string to 32-bit unsigned value, one character per transaction.
// A final character's result passes through the input register, then the step logic
// into the result register; a full result register holds it in the input register.
// Throughput: one character per cycle while no final character waits on a full result register.
// Reset: synchronous active-low i_rst_n clears parser state and both valid flags.
module ascii_number_to_uint32 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    a2u_in_if.sink        i_in,
    a2u_out_if.source     o_out
);
    import a2u_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_character;
    logic         r_last_char;
    t_parse_state r_state;
    t_parse_state n_state;
    logic         r_out_valid;
    logic [31:0]  r_value;
    logic         r_status;
    logic [31:0]  n_value;
    logic         n_status;
    logic         out_free;
    logic         step_go;

    // Handshake: a non-final character never waits for the result register
    assign out_free   = !r_out_valid || o_out.ready;
    assign step_go    = r_in_valid && (!r_last_char || out_free);
    assign i_in.ready = !r_in_valid || step_go;

    a2u_step u_step (
        .i_state      (r_state),
        .i_character  (r_character),
        .i_last_char  (r_last_char),
        .o_next_state (n_state),
        .o_value      (n_value),
        .o_status     (n_status)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_character <= i_in.character;
            r_last_char <= i_in.last_char;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step_go && r_last_char;
        end
        if (out_free && step_go && r_last_char) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_value;
    assign o_out.status = r_status;

`ifndef SYNTHESIS
    // A final character leaves the parser in its clean state
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_go && r_last_char |=> r_state == '0)
        else $error("parser state not cleared after final character");

    // A failure result carries a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == STATUS_FAIL) |-> r_value == 32'd0)
        else $error("failure result with non-zero value");

    // Position saturates and never reaches the unused code
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.char_position != 2'd3)
        else $error("character position out of range");

    // Once failed, later non-final characters leave the accumulator alone
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_go && r_state.failed && !r_last_char |=>
            r_state.failed && (r_state.accumulator == $past(r_state.accumulator)))
        else $error("failed string changed the accumulator");

    // A result is only produced when the result register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid)
        else $error("pending result dropped");
`endif

endmodule

FILE: hw/rtl/a2u_step.sv
// One character step of the ASCII number parser: next state and result.
// Pure combinational logic.
// Depends on a2u_pkg.
module a2u_step (
    input  a2u_pkg::t_parse_state i_state,
    input  logic [7:0]            i_character,
    input  logic                  i_last_char,
    output a2u_pkg::t_parse_state o_next_state,
    output logic [31:0]           o_value,
    output logic                  o_status
);
    import a2u_pkg::*;

    logic        is_dec;
    logic        is_hex_letter;
    logic [3:0]  hex_digit;
    logic [31:0] dec_next;
    logic        is_x;
    t_parse_state n_state;

    // Character classes and digit values
    assign is_dec        = (i_character >= CH_0) && (i_character <= CH_9);
    assign is_hex_letter = ((i_character >= CH_A_UP) && (i_character <= CH_F_UP)) ||
                           ((i_character >= CH_A_LO) && (i_character <= CH_F_LO));
    // letters A-F / a-f have low nibble 1..6, value is that plus nine
    assign hex_digit     = is_dec ? i_character[3:0] : (i_character[3:0] + 4'd9);
    assign is_x          = (i_character == CH_X_LO) || (i_character == CH_X_UP);

    // acc * 10 + digit as shift-and-add, truncated (overflow caught separately)
    assign dec_next = {i_state.accumulator[28:0], 3'b000}
                    + {i_state.accumulator[30:0], 1'b0}
                    + {28'd0, i_character[3:0]};

    // Next state
    always_comb begin
        n_state = i_state;
        if (!i_state.failed) begin
            if (i_state.hex_mode) begin
                if (i_state.accumulator > HEX_LIMIT) begin
                    n_state.failed = 1'b1;
                end else if (!(is_dec || is_hex_letter)) begin
                    n_state.failed = 1'b1;
                end else begin
                    n_state.accumulator = {i_state.accumulator[27:0], hex_digit};
                end
            end else if ((i_state.char_position == POS_SECOND) &&
                         (i_state.accumulator == 32'd0) && is_x && !i_last_char) begin
                n_state.hex_mode = 1'b1;
            end else if (!is_dec) begin
                n_state.failed = 1'b1;
            end else if (((i_state.accumulator == DEC_LIMIT) && (i_character > CH_5)) ||
                         (i_state.accumulator > DEC_LIMIT)) begin
                n_state.failed = 1'b1;
            end else begin
                n_state.accumulator = dec_next;
            end
        end
        if (i_state.char_position != POS_LATER) begin
            n_state.char_position = i_state.char_position + 2'd1;
        end
    end

    // Result of a final character, then a clean state
    assign o_value      = n_state.failed ? 32'd0 : n_state.accumulator;
    assign o_status     = n_state.failed ? STATUS_FAIL : STATUS_OK;
    assign o_next_state = i_last_char ? '0 : n_state;

endmodule

FILE: bench/ascii_number_to_uint32_test.sv
// Self-checking testbench for the ASCII number to uint32 parser.
// Drives character strings through a2u_in_if and checks results on a2u_out_if.
// Depends on a2u_pkg, a2u_ifs.sv and ascii_number_to_uint32.
module ascii_number_to_uint32_test;
    timeunit 1ns;
    timeprecision 1ps;

    import a2u_pkg::*;

    localparam logic [31:0] DEC_BASE     = 32'd10;
    localparam int          RANDOM_CHARS = 1625;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 20;

    typedef logic [7:0] t_text [$];

    typedef struct packed {
        logic [31:0] value;
        logic        status;
    } t_number;

    // One row of the directed table; known marks a hand-typed result
    typedef struct {
        logic [7:0]  ch;
        logic        last_char;
        logic        known;
        logic [31:0] value;
        logic        status;
    } t_row;

    localparam int N_DIRECTED = 25;

    t_row directed_rows [N_DIRECTED] = '{
        '{CH_0,    1'b1, 1'b1, 32'd0,          STATUS_OK},
        '{CH_9,    1'b1, 1'b1, 32'd9,          STATUS_OK},
        '{8'hFF,   1'b1, 1'b1, 32'd0,          STATUS_FAIL},
        '{8'h00,   1'b1, 1'b1, 32'd0,          STATUS_FAIL},
        // bare prefix is read as decimal, so the x is invalid
        '{CH_0,    1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_X_LO, 1'b1, 1'b1, 32'd0,          STATUS_FAIL},
        '{CH_0,    1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_X_UP, 1'b1, 1'b1, 32'd0,          STATUS_FAIL},
        // shortest hex string
        '{CH_0,    1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_X_UP, 1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_A_LO, 1'b1, 1'b1, 32'd10,         STATUS_OK},
        // bytes after a failure are ignored
        '{CH_A_UP, 1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_5,    1'b1, 1'b1, 32'd0,          STATUS_FAIL},
        // largest value in hex
        '{CH_0,    1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_X_LO, 1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_F_UP, 1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_F_LO, 1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_F_UP, 1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_F_LO, 1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_F_UP, 1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_F_LO, 1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_F_UP, 1'b0, 1'b0, 32'd0,          STATUS_OK},
        '{CH_F_LO, 1'b1, 1'b1, 32'hFFFF_FFFF,  STATUS_OK},
        // plain decimal, left to the predictor
        '{CH_0 + 8'd1, 1'b0, 1'b0, 32'd0,      STATUS_OK},
        '{CH_5,    1'b1, 1'b0, 32'd0,          STATUS_OK}
    };

    logic i_clk;
    logic i_rst_n;

    a2u_in_if  char_if ();
    a2u_out_if num_if ();

    ascii_number_to_uint32 uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_if),
        .o_out   (num_if)
    );

    t_parse_state parse_st;
    t_number      expected_nums [$];
    int           gap_pct;
    int           stall_pct;
    int           chars_sent;
    int           mismatches;
    int           cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Parser model: consumes one character, returns 1 when a result is due
    function automatic bit parse_step(input logic [7:0] ch, input logic lst,
                                      output t_number num);
        logic [7:0] digit;
        bit         hex_ok;
        hex_ok = 1'b1;
        digit  = 8'd0;
        num    = '0;
        if (!parse_st.failed) begin
            if (parse_st.hex_mode) begin
                if (ch >= CH_0 && ch <= CH_9) begin
                    digit = ch - CH_0;
                end else if (ch >= CH_A_UP && ch <= CH_F_UP) begin
                    digit = ch - CH_A_UP + 8'd10;
                end else if (ch >= CH_A_LO && ch <= CH_F_LO) begin
                    digit = ch - CH_A_LO + 8'd10;
                end else begin
                    hex_ok = 1'b0;
                end
                if (parse_st.accumulator > HEX_LIMIT || !hex_ok) begin
                    parse_st.failed = 1'b1;
                end else begin
                    parse_st.accumulator = {parse_st.accumulator[27:0], digit[3:0]};
                end
            end else if (parse_st.char_position == POS_SECOND && parse_st.accumulator == 0 &&
                         (ch == CH_X_LO || ch == CH_X_UP) && !lst) begin
                // leading zero then x with more to come: hexadecimal
                parse_st.hex_mode = 1'b1;
            end else if (ch < CH_0 || ch > CH_9 || parse_st.accumulator > DEC_LIMIT ||
                         (parse_st.accumulator == DEC_LIMIT && ch > CH_5)) begin
                parse_st.failed = 1'b1;
            end else begin
                digit = ch - CH_0;
                parse_st.accumulator = parse_st.accumulator * DEC_BASE + 32'(digit);
            end
        end
        if (parse_st.char_position != POS_LATER) begin
            parse_st.char_position = parse_st.char_position + 2'd1;
        end
        if (!lst) begin
            return 1'b0;
        end
        num.value  = parse_st.failed ? 32'd0 : parse_st.accumulator;
        num.status = parse_st.failed ? STATUS_FAIL : STATUS_OK;
        parse_st   = '0;
        return 1'b1;
    endfunction

    // Append the decimal digits of v
    task automatic add_decimal(inout t_text txt, input longint unsigned v);
        t_text digs;
        digs = {};
        do begin
            digs.push_front(CH_0 + 8'(v % 64'd10));
            v = v / 64'd10;
        end while (v != 0);
        txt = {txt, digs};
    endtask

    // Append ndig hex digits of random case; all_f gives the largest digits
    task automatic add_hex(inout t_text txt, input int ndig, input bit all_f);
        int unsigned d;
        for (int k = 0; k < ndig; k++) begin
            d = all_f ? 15 : $urandom_range(15);
            // more than eight significant digits must overflow
            if (k == 0 && ndig > 8) begin
                d = $urandom_range(1, 15);
            end
            if (d < 10) begin
                txt.push_back(CH_0 + 8'(d));
            end else begin
                txt.push_back(($urandom_range(1) ? CH_A_UP : CH_A_LO) + 8'(d - 10));
            end
        end
    endtask

    // Random string: mostly well-formed numbers, some broken, some noise
    task automatic build_text(output t_text txt);
        int unsigned     kind;
        int              ndig;
        longint unsigned v;
        txt  = {};
        kind = $urandom_range(99);
        if (kind < 30) begin
            case ($urandom_range(3))
                0:       v = 64'($urandom);
                1:       v = 64'($urandom_range(999));
                2:       v = 64'd4294967295 - 64'($urandom_range(20));
                default: v = 64'($urandom_range(99999));
            endcase
            add_decimal(txt, v);
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 3)) txt.push_front(CH_0);
            end
        end else if (kind < 40) begin
            // decimal overflow, both at the limit and well past it
            case ($urandom_range(2))
                0:       v = 64'd4294967296 + 64'($urandom_range(3));
                1:       v = 64'd4294967296 + 64'($urandom);
                default: v = {$urandom, $urandom} % 64'd1000000000000;
            endcase
            add_decimal(txt, v);
        end else if (kind < 65) begin
            txt  = {CH_0, ($urandom_range(1) ? CH_X_LO : CH_X_UP)};
            ndig = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
            if ($urandom_range(9) == 0) begin
                add_hex(txt, 8, 1'b1);
            end else begin
                add_hex(txt, ndig, 1'b0);
            end
        end else if (kind < 75) begin
            // well-formed number with one byte corrupted
            if ($urandom_range(1)) begin
                txt = {CH_0, CH_X_LO};
                add_hex(txt, $urandom_range(1, 8), 1'b0);
            end else begin
                add_decimal(txt, 64'($urandom));
            end
            txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
        end else if (kind < 85) begin
            case ($urandom_range(3))
                0:       txt = {CH_0, ($urandom_range(1) ? CH_X_LO : CH_X_UP)};
                1:       txt = {CH_0, CH_0, CH_X_LO, CH_5};
                2:       txt = {CH_X_UP, CH_0, CH_9};
                default: txt = {8'($urandom_range(255))};
            endcase
        end else begin
            repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom_range(255)));
        end
    endtask

    // Offer one character; on acceptance predict and queue the result
    task automatic send_char(input logic [7:0] ch, input logic lst,
                             input logic known, input t_number known_num);
        t_number num;
        while ($urandom_range(99) < gap_pct) begin
            char_if.valid     <= 1'b0;
            char_if.character <= 8'($urandom_range(255));
            @(negedge i_clk);
        end
        char_if.valid     <= 1'b1;
        char_if.character <= ch;
        char_if.last_char <= lst;
        @(posedge i_clk);
        while (!char_if.ready) @(posedge i_clk);
        if (parse_step(ch, lst, num)) begin
            expected_nums.push_back(known ? known_num : num);
        end
        chars_sent++;
        @(negedge i_clk);
    endtask

    // Result side back-pressure
    initial begin
        num_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            num_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_number want;
        if (i_rst_n && num_if.valid && num_if.ready) begin
            if (expected_nums.size() == 0) begin
                $error("unexpected result: value %0d status %0d", num_if.value, num_if.status);
                mismatches++;
            end else begin
                want = expected_nums.pop_front();
                if (num_if.value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, num_if.value);
                    mismatches++;
                end
                if (num_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, num_if.status);
                    mismatches++;
                end
            end
        end
    end

    // Run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_text   txt;
        t_number tn;
        i_rst_n           = 1'b0;
        char_if.valid     = 1'b0;
        char_if.character = 8'd0;
        char_if.last_char = 1'b0;
        parse_st          = '0;
        gap_pct           = 0;
        stall_pct         = 0;
        chars_sent        = 0;
        mismatches        = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (directed_rows[i]) begin
            tn.value  = directed_rows[i].value;
            tn.status = directed_rows[i].status;
            send_char(directed_rows[i].ch, directed_rows[i].last_char,
                      directed_rows[i].known, tn);
        end

        // Random strings over four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 71; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 71; end
                default: begin gap_pct = 10; stall_pct = 10; end
            endcase
            while (chars_sent < N_DIRECTED + (ph + 1) * RANDOM_CHARS / 4) begin
                build_text(txt);
                foreach (txt[k]) begin
                    send_char(txt[k], k == txt.size() - 1, 1'b0, '0);
                end
            end
        end
        char_if.valid <= 1'b0;
        stall_pct = 0;

        // Drain outstanding results, then allow for stray ones
        while (expected_nums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_nums.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/a2u_pkg.sv
hw/rtl/a2u_ifs.sv
hw/rtl/a2u_step.sv
hw/rtl/ascii_number_to_uint32.sv
bench/ascii_number_to_uint32_test.sv
